/* src/assert_macros.svh */
// Assertion macros shared by the RTL that checks itself.
// Every macro samples on clk and is disabled while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("same-cycle implication failed");

// Next-cycle implication.
`define ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle implication failed");

`endif

/* src/owtr_pkg.sv */
// Package for the 1-Wire temperature reader: config and result types,
// register indexes, reset values and the command byte table. No dependencies.
package owtr_pkg;

  localparam int CfgIdxW = 3;
  localparam int CfgDataW = 20;

  localparam logic [CfgIdxW-1:0] REG_RESET_LOW   = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_PRES_TMO    = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_GAP         = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_SLOT        = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_SAMPLE      = 3'd4;
  localparam logic [CfgIdxW-1:0] REG_RECOVERY    = 3'd5;
  localparam logic [CfgIdxW-1:0] REG_CONV_WAIT   = 3'd6;

  localparam logic [9:0]  RESET_LOW_DEF  = 10'd642;
  localparam logic [12:0] PRES_TMO_DEF   = 13'd6000;
  localparam logic [10:0] GAP_DEF        = 11'd1000;
  localparam logic [6:0]  SLOT_DEF       = 7'd68;
  localparam logic [4:0]  SAMPLE_DEF     = 5'd6;
  localparam logic [3:0]  RECOVERY_DEF   = 4'd1;
  localparam logic [19:0] CONV_WAIT_DEF  = 20'd750000;

  localparam logic [7:0] CMD_SKIP_ROM  = 8'hCC;
  localparam logic [7:0] CMD_CONVERT   = 8'h44;
  localparam logic [7:0] CMD_READ_PAD  = 8'hBE;

  typedef struct packed {
    logic [9:0]  reset_low_us;
    logic [12:0] presence_timeout_us;
    logic [10:0] after_reset_gap_us;
    logic [6:0]  slot_us;
    logic [4:0]  sample_us;
    logic [3:0]  recovery_us;
    logic [19:0] convert_wait_us;
  } owtr_cfg_t;

  typedef struct packed {
    logic               drive_low;
    logic               busy_res;
    logic               done_res;
    logic               no_presence;
    logic signed [15:0] raw_temperature;
  } owtr_res_t;

  // Command bytes in the order they go out on the bus.
  function automatic logic [7:0] cmd_byte(input logic [1:0] idx);
    logic [7:0] b;
    case (idx)
      2'd0:    b = CMD_SKIP_ROM;
      2'd1:    b = CMD_CONVERT;
      2'd2:    b = CMD_SKIP_ROM;
      default: b = CMD_READ_PAD;
    endcase
    return b;
  endfunction

endpackage

/* src/owtr_if.sv */
// Valid/ready channel interfaces for the 1-Wire temperature reader.
// Input carries one tick item, output one result item. No dependencies.
interface owtr_in_if;
  logic valid;
  logic ready;
  logic start_req;
  logic line_in;
  modport source (output valid, start_req, line_in, input ready);
  modport sink   (input valid, start_req, line_in, output ready);
endinterface

interface owtr_out_if;
  logic               valid;
  logic               ready;
  logic               drive_low;
  logic               busy_res;
  logic               done_res;
  logic               no_presence;
  logic signed [15:0] raw_temperature;
  modport source (output valid, drive_low, busy_res, done_res, no_presence, raw_temperature,
                  input ready);
  modport sink   (input valid, drive_low, busy_res, done_res, no_presence, raw_temperature,
                  output ready);
endinterface

/* src/owtr_cfg.sv */
// Timing register file of the 1-Wire temperature reader.
// Depends on owtr_pkg for register indexes, reset values and owtr_cfg_t.
module owtr_cfg import owtr_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                we,
  input  logic [CfgIdxW-1:0]  idx,
  input  logic [CfgDataW-1:0] wdata,
  output owtr_cfg_t           cfg
);

  owtr_cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.reset_low_us        <= RESET_LOW_DEF;
      cfg_r.presence_timeout_us <= PRES_TMO_DEF;
      cfg_r.after_reset_gap_us  <= GAP_DEF;
      cfg_r.slot_us             <= SLOT_DEF;
      cfg_r.sample_us           <= SAMPLE_DEF;
      cfg_r.recovery_us         <= RECOVERY_DEF;
      cfg_r.convert_wait_us     <= CONV_WAIT_DEF;
    end else if (we) begin
      case (idx)
        REG_RESET_LOW: cfg_r.reset_low_us        <= wdata[9:0];
        REG_PRES_TMO:  cfg_r.presence_timeout_us <= wdata[12:0];
        REG_GAP:       cfg_r.after_reset_gap_us  <= wdata[10:0];
        REG_SLOT:      cfg_r.slot_us             <= wdata[6:0];
        REG_SAMPLE:    cfg_r.sample_us           <= wdata[4:0];
        REG_RECOVERY:  cfg_r.recovery_us         <= wdata[3:0];
        REG_CONV_WAIT: cfg_r.convert_wait_us     <= wdata[19:0];
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

/* src/owtr_seq.sv */
// Bus sequencer of the 1-Wire temperature reader: one step per tick item.
// Depends on owtr_pkg for owtr_cfg_t, owtr_res_t and the command table.
module owtr_seq import owtr_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      step,
  input  logic      start_req,
  input  logic      line_in,
  input  owtr_cfg_t cfg,
  output owtr_res_t res
);

  typedef enum logic [2:0] {
    PH_IDLE, PH_RST, PH_PRES, PH_GAP, PH_WSLOT, PH_RSLOT, PH_REC, PH_CONV
  } phase_t;

  phase_t      phase_r, phase_nxt;
  logic [19:0] timer_r, timer_nxt;
  logic [2:0]  bit_idx_r, bit_idx_nxt;
  logic [2:0]  byte_step_r, byte_step_nxt;
  logic [7:0]  shift_r, shift_nxt;
  logic [7:0]  low_hold_r, low_hold_nxt;
  logic [15:0] temp_hold_r, temp_hold_nxt;

  logic [20:0] tick_inc;
  logic [4:0]  sample_pt;
  logic [6:0]  rslot_end;
  logic        done, nop;
  logic        drive_nxt;

  assign tick_inc  = {1'b0, timer_r} + 21'd1;
  // sample point 0 falls on the driven tick, so it moves to 1
  assign sample_pt = (cfg.sample_us == 5'd0) ? 5'd1 : cfg.sample_us;
  // read slot is stretched past the sample point when needed
  assign rslot_end = (cfg.slot_us > 7'({2'b0, sample_pt} + 7'd1)) ? cfg.slot_us
                                                                  : 7'({2'b0, sample_pt} + 7'd1);

  always_comb begin
    phase_nxt     = phase_r;
    timer_nxt     = tick_inc[19:0];
    bit_idx_nxt   = bit_idx_r;
    byte_step_nxt = byte_step_r;
    shift_nxt     = shift_r;
    low_hold_nxt  = low_hold_r;
    temp_hold_nxt = temp_hold_r;
    done          = 1'b0;
    nop           = 1'b0;

    case (phase_r)
      PH_IDLE: begin
        timer_nxt = timer_r;
        if (start_req) begin
          byte_step_nxt = 3'd0;
          phase_nxt     = PH_RST;
          timer_nxt     = '0;
        end
      end
      PH_RST: begin
        if (tick_inc >= 21'(cfg.reset_low_us)) begin
          phase_nxt = PH_PRES;
          timer_nxt = '0;
        end
      end
      PH_PRES: begin
        if (!line_in) begin
          phase_nxt = PH_GAP;
          timer_nxt = '0;
        end else if (tick_inc >= 21'(cfg.presence_timeout_us)) begin
          byte_step_nxt = 3'd0;
          phase_nxt     = PH_IDLE;
          timer_nxt     = '0;
          done          = 1'b1;
          nop           = 1'b1;
        end
      end
      PH_GAP: begin
        if (tick_inc >= 21'(cfg.after_reset_gap_us)) begin
          bit_idx_nxt = 3'd0;
          timer_nxt   = '0;
          if (byte_step_r < 3'd4) begin
            shift_nxt = cmd_byte(byte_step_r[1:0]);
            phase_nxt = PH_WSLOT;
          end else begin
            shift_nxt = '0;
            phase_nxt = PH_RSLOT;
          end
        end
      end
      PH_WSLOT: begin
        if (tick_inc >= 21'(cfg.slot_us)) begin
          shift_nxt = {1'b0, shift_r[7:1]};
          phase_nxt = PH_REC;
          timer_nxt = '0;
        end
      end
      PH_RSLOT: begin
        if (timer_r == 20'(sample_pt)) shift_nxt = {line_in, shift_r[7:1]};
        if (tick_inc >= 21'(rslot_end)) begin
          phase_nxt = PH_REC;
          timer_nxt = '0;
        end
      end
      PH_REC: begin
        if (tick_inc >= 21'(cfg.recovery_us)) begin
          timer_nxt = '0;
          if (bit_idx_r != 3'd7) begin
            bit_idx_nxt = bit_idx_r + 3'd1;
            phase_nxt   = (byte_step_r < 3'd4) ? PH_WSLOT : PH_RSLOT;
          end else begin
            // byte finished: pick the next byte, the conversion wait or the end of the sequence
            bit_idx_nxt = 3'd0;
            case (byte_step_r)
              3'd0: begin
                byte_step_nxt = 3'd1;
                shift_nxt     = cmd_byte(2'd1);
                phase_nxt     = PH_WSLOT;
              end
              3'd1: begin
                byte_step_nxt = 3'd2;
                bit_idx_nxt   = bit_idx_r;
                phase_nxt     = PH_CONV;
              end
              3'd2: begin
                byte_step_nxt = 3'd3;
                shift_nxt     = cmd_byte(2'd3);
                phase_nxt     = PH_WSLOT;
              end
              3'd3: begin
                byte_step_nxt = 3'd4;
                shift_nxt     = '0;
                phase_nxt     = PH_RSLOT;
              end
              3'd4: begin
                low_hold_nxt  = shift_r;
                byte_step_nxt = 3'd5;
                shift_nxt     = '0;
                phase_nxt     = PH_RSLOT;
              end
              default: begin
                temp_hold_nxt = {shift_r, low_hold_r};
                byte_step_nxt = 3'd0;
                bit_idx_nxt   = bit_idx_r;
                phase_nxt     = PH_IDLE;
                done          = 1'b1;
              end
            endcase
          end
        end
      end
      PH_CONV: begin
        if (tick_inc >= 21'(cfg.convert_wait_us)) begin
          phase_nxt = PH_RST;
          timer_nxt = '0;
        end
      end
      default: begin
        phase_nxt = PH_IDLE;
        timer_nxt = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_IDLE;
      timer_r     <= '0;
      bit_idx_r   <= '0;
      byte_step_r <= '0;
      shift_r     <= '0;
      low_hold_r  <= '0;
      temp_hold_r <= '0;
    end else if (step) begin
      phase_r     <= phase_nxt;
      timer_r     <= timer_nxt;
      bit_idx_r   <= bit_idx_nxt;
      byte_step_r <= byte_step_nxt;
      shift_r     <= shift_nxt;
      low_hold_r  <= low_hold_nxt;
      temp_hold_r <= temp_hold_nxt;
    end
  end

  // drive level for the next tick follows the state being entered
  always_comb begin
    case (phase_nxt)
      PH_RST:   drive_nxt = 1'b1;
      PH_WSLOT: drive_nxt = (timer_nxt == '0) || !shift_nxt[0];
      PH_RSLOT: drive_nxt = (timer_nxt == '0);
      default:  drive_nxt = 1'b0;
    endcase
  end

  assign res = {drive_nxt, (phase_nxt != PH_IDLE), done, nop, temp_hold_nxt};

endmodule

/* src/one_wire_temperature_reader.sv */
// Top level of the 1-Wire temperature reader: input register, sequencer,
// result register. Depends on owtr_pkg, owtr_if, owtr_cfg, owtr_seq, assert_macros.svh.
//
//   channel  dir  handshake      payload
//   in_ch    in   valid/ready    start_req, line_in (one microsecond tick)
//   out_ch   out  valid/ready    drive_low, busy_res, done_res, no_presence,
//                                raw_temperature
//   cfg_*    in   write enable   cfg_index, cfg_wdata (seven timing registers)
//
// One tick item enters per cycle while the output side does not stall; its result passes
// through the input register and the result register around the sequencer step.
// The sequencer state and the timer advance only when an item moves into the
// result register, so stalls on either side never skip or repeat a tick.
// Synchronous active-low reset puts the sequencer in idle and the timing
// registers at their defaults; no clearing pass.
`include "assert_macros.svh"

module one_wire_temperature_reader import owtr_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  owtr_in_if.sink             in_ch,
  owtr_out_if.source          out_ch,
  input  logic                cfg_we,
  input  logic [CfgIdxW-1:0]  cfg_index,
  input  logic [CfgDataW-1:0] cfg_wdata
);

  logic      in_valid_r, in_start_r, in_line_r;
  logic      out_valid_r;
  owtr_res_t out_res_r;
  owtr_res_t res;
  owtr_cfg_t cfg;
  logic      adv;

  // item moves from the input register to the result register
  assign adv         = in_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready = !in_valid_r || adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      in_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      in_start_r <= in_ch.start_req;
      in_line_r  <= in_ch.line_in;
    end
  end

  owtr_cfg u_cfg (
    .clk   (clk),
    .rst_n (rst_n),
    .we    (cfg_we),
    .idx   (cfg_index),
    .wdata (cfg_wdata),
    .cfg   (cfg)
  );

  owtr_seq u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (adv),
    .start_req (in_start_r),
    .line_in   (in_line_r),
    .cfg       (cfg),
    .res       (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) out_res_r <= res;
  end

  assign out_ch.valid           = out_valid_r;
  assign out_ch.drive_low       = out_res_r.drive_low;
  assign out_ch.busy_res        = out_res_r.busy_res;
  assign out_ch.done_res        = out_res_r.done_res;
  assign out_ch.no_presence     = out_res_r.no_presence;
  assign out_ch.raw_temperature = out_res_r.raw_temperature;

  `ASSERT_NEXT(a_adv_fills_out, adv, out_valid_r)
  `ASSERT_IMP(a_nop_with_done, out_valid_r && out_res_r.no_presence, out_res_r.done_res)
  `ASSERT_IMP(a_done_not_busy, out_valid_r && out_res_r.done_res, !out_res_r.busy_res)
  `ASSERT_IMP(a_drive_when_busy, out_valid_r && out_res_r.drive_low, out_res_r.busy_res)

endmodule

/* tb/sv/tb_one_wire_temperature_reader.sv */
// Testbench for one_wire_temperature_reader: a sensor-side bus model picks each tick item,
// a sequence tracker predicts every result item and checks what comes out.
// Depends on owtr_pkg, owtr_if and the RTL top level.
module tb_one_wire_temperature_reader;
  import owtr_pkg::*;

  localparam int WatchdogLimit = 5000;
  localparam int ReportCap = 100;

  typedef enum logic [4:0] {
    PH_IDLE, PH_RST, PH_PRES, PH_GAP, PH_WSLOT, PH_RSLOT, PH_REC, PH_CONV
  } seq_phase_t;

  // Tracks the bus sequencer tick by tick and holds the result items still owed.
  class owtr_tracker_t;
    owtr_cfg_t   cfg;
    seq_phase_t  phase;
    int unsigned tick_timer;
    logic [2:0]  bit_index;
    logic [2:0]  byte_step;
    logic [7:0]  shift_byte;
    logic [7:0]  low_byte;
    logic [15:0] temp_word;
    logic        drive_next;
    owtr_res_t   pending[$];
    int          fail_count;
    int          n_ticks;
    int          n_done;
    int          n_absent;
    int          n_checked;

    function new();
      cfg.reset_low_us        = RESET_LOW_DEF;
      cfg.presence_timeout_us = PRES_TMO_DEF;
      cfg.after_reset_gap_us  = GAP_DEF;
      cfg.slot_us             = SLOT_DEF;
      cfg.sample_us           = SAMPLE_DEF;
      cfg.recovery_us         = RECOVERY_DEF;
      cfg.convert_wait_us     = CONV_WAIT_DEF;
      phase = PH_IDLE;
      tick_timer = 0;
      bit_index = '0;
      byte_step = '0;
      shift_byte = '0;
      low_byte = '0;
      temp_word = '0;
      drive_next = 1'b0;
      fail_count = 0;
      n_ticks = 0;
      n_done = 0;
      n_absent = 0;
      n_checked = 0;
    endfunction

    function void enter(seq_phase_t p);
      phase = p;
      tick_timer = 0;
    endfunction

    function void load_byte();
      bit_index = '0;
      if (byte_step < 3'd4) begin
        case (byte_step)
          3'd1:    shift_byte = CMD_CONVERT;
          3'd3:    shift_byte = CMD_READ_PAD;
          default: shift_byte = CMD_SKIP_ROM;
        endcase
        enter(PH_WSLOT);
      end else begin
        shift_byte = '0;
        enter(PH_RSLOT);
      end
    endfunction

    // Byte order: skip-ROM, convert, (wait), skip-ROM, read-pad, low byte, high byte.
    function logic finish_byte();
      case (byte_step)
        3'd0: begin
          byte_step = 3'd1;
          load_byte();
        end
        3'd1: begin
          byte_step = 3'd2;
          enter(PH_CONV);
        end
        3'd2: begin
          byte_step = 3'd3;
          load_byte();
        end
        3'd3: begin
          byte_step = 3'd4;
          load_byte();
        end
        3'd4: begin
          low_byte = shift_byte;
          byte_step = 3'd5;
          load_byte();
        end
        default: begin
          temp_word = {shift_byte, low_byte};
          byte_step = '0;
          enter(PH_IDLE);
          return 1'b1;
        end
      endcase
      return 1'b0;
    endfunction

    function void note_tick(logic start, logic line);
      int unsigned t;
      int unsigned nxt;
      int unsigned samp;
      int unsigned slot_end;
      logic        done;
      logic        absent;
      owtr_res_t   r;
      t = tick_timer;
      nxt = t + 1;
      done = 1'b0;
      absent = 1'b0;
      case (phase)
        PH_IDLE: begin
          if (start) begin
            byte_step = '0;
            enter(PH_RST);
          end
        end
        PH_RST: begin
          if (nxt >= cfg.reset_low_us) enter(PH_PRES);
          else tick_timer = nxt;
        end
        PH_PRES: begin
          if (!line) begin
            enter(PH_GAP);
          end else if (nxt >= cfg.presence_timeout_us) begin
            byte_step = '0;
            enter(PH_IDLE);
            done = 1'b1;
            absent = 1'b1;
          end else begin
            tick_timer = nxt;
          end
        end
        PH_GAP: begin
          if (nxt >= cfg.after_reset_gap_us) load_byte();
          else tick_timer = nxt;
        end
        PH_WSLOT: begin
          if (nxt >= cfg.slot_us) begin
            shift_byte = shift_byte >> 1;
            enter(PH_REC);
          end else begin
            tick_timer = nxt;
          end
        end
        PH_RSLOT: begin
          // tick 0 of a read slot is driven, so the sample point is at least 1
          samp = (cfg.sample_us == 0) ? 1 : cfg.sample_us;
          slot_end = (cfg.slot_us > samp + 1) ? cfg.slot_us : samp + 1;
          if (t == samp) shift_byte = {line, shift_byte[7:1]};
          if (nxt >= slot_end) enter(PH_REC);
          else tick_timer = nxt;
        end
        PH_REC: begin
          if (nxt >= cfg.recovery_us) begin
            if (bit_index < 3'd7) begin
              bit_index++;
              if (byte_step < 3'd4) enter(PH_WSLOT);
              else enter(PH_RSLOT);
            end else begin
              done = finish_byte();
            end
          end else begin
            tick_timer = nxt;
          end
        end
        PH_CONV: begin
          if (nxt >= cfg.convert_wait_us) enter(PH_RST);
          else tick_timer = nxt;
        end
        default: enter(PH_IDLE);
      endcase

      case (phase)
        PH_RST:   drive_next = 1'b1;
        PH_WSLOT: drive_next = (tick_timer == 0) || !shift_byte[0];
        PH_RSLOT: drive_next = (tick_timer == 0);
        default:  drive_next = 1'b0;
      endcase

      r.drive_low = drive_next;
      r.busy_res = (phase != PH_IDLE);
      r.done_res = done;
      r.no_presence = absent;
      r.raw_temperature = temp_word;
      pending.push_back(r);
      n_ticks++;
      if (done) n_done++;
      if (absent) n_absent++;
    endfunction

    function void report(string what);
      fail_count++;
      if (fail_count <= ReportCap) $display("MISMATCH: %s", what);
    endfunction

    function void check_result(owtr_res_t got);
      owtr_res_t want;
      if (pending.size() == 0) begin
        report($sformatf("result item with nothing pending: %p", got));
        return;
      end
      want = pending.pop_front();
      if (got.drive_low !== want.drive_low)
        report($sformatf("item %0d drive_low got %b want %b",
                         n_checked, got.drive_low, want.drive_low));
      if (got.busy_res !== want.busy_res)
        report($sformatf("item %0d busy_res got %b want %b",
                         n_checked, got.busy_res, want.busy_res));
      if (got.done_res !== want.done_res)
        report($sformatf("item %0d done_res got %b want %b",
                         n_checked, got.done_res, want.done_res));
      if (got.no_presence !== want.no_presence)
        report($sformatf("item %0d no_presence got %b want %b",
                         n_checked, got.no_presence, want.no_presence));
      if (got.raw_temperature !== want.raw_temperature)
        report($sformatf("item %0d raw_temperature got %h want %h",
                         n_checked, got.raw_temperature, want.raw_temperature));
      n_checked++;
    endfunction
  endclass

  logic                clk;
  logic                rst_n;
  logic                cfg_we;
  logic [CfgIdxW-1:0]  cfg_index;
  logic [CfgDataW-1:0] cfg_wdata;
  logic                hold_rx;
  int                  rx_idle_pct;
  int                  tx_idle_pct;
  int                  n_settings;
  int                  quiet_cycles;

  // sensor side of the bus
  logic                dev_absent;
  int unsigned         dev_delay;
  logic [15:0]         sensor_word;

  owtr_tracker_t trk;

  owtr_in_if  in_ch();
  owtr_out_if out_ch();

  one_wire_temperature_reader i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    if (!rst_n) out_ch.ready <= 1'b0;
    else out_ch.ready <= !hold_rx && ($urandom_range(99) >= rx_idle_pct);
  end

  always @(posedge clk) begin
    owtr_res_t got;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got.drive_low = out_ch.drive_low;
      got.busy_res = out_ch.busy_res;
      got.done_res = out_ch.done_res;
      got.no_presence = out_ch.no_presence;
      got.raw_temperature = out_ch.raw_temperature;
      trk.check_result(got);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles + 1 >= WatchdogLimit) begin
      $display("watchdog: no item moved for %0d cycles", WatchdogLimit);
      $display("CHECKS FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic hold_receiver(input int n);
    hold_rx <= 1'b1;
    repeat (n) @(posedge clk);
    hold_rx <= 1'b0;
  endtask

  task automatic send_item(input logic start, input logic line);
    int gap;
    gap = 0;
    while (gap < 60 && $urandom_range(99) < tx_idle_pct) gap++;
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.start_req <= start;
    in_ch.line_in <= line;
    do @(posedge clk); while (!in_ch.ready);
    trk.note_tick(start, line);
  endtask

  // Bus level for the next tick: master drive wins, else the sensor, plus a little noise.
  task automatic send_modeled(input int start_pct, input int absent_pct);
    logic        st;
    logic        ln;
    int unsigned span;
    if (trk.phase == PH_PRES && trk.tick_timer == 0) begin
      span = (trk.cfg.presence_timeout_us > 40) ? 40 : trk.cfg.presence_timeout_us;
      dev_absent = ($urandom_range(99) < absent_pct);
      dev_delay = $urandom_range(span);
    end
    ln = !trk.drive_next;
    if (!trk.drive_next) begin
      case (trk.phase)
        PH_PRES:  if (!dev_absent && trk.tick_timer >= dev_delay) ln = 1'b0;
        PH_RSLOT: ln = sensor_word[{trk.byte_step == 3'd5, trk.bit_index}];
        default:  ;
      endcase
    end
    // a silent sensor must stay silent, or the sequence runs into the conversion wait
    if (!(trk.phase == PH_PRES && dev_absent) && $urandom_range(99) < 3)
      ln = 1'($urandom_range(1));
    if (trk.phase == PH_IDLE) begin
      st = ($urandom_range(99) < start_pct);
      if (st) begin
        case ($urandom_range(5))
          0:       sensor_word = 16'h8000;
          1:       sensor_word = 16'h7FFF;
          2:       sensor_word = 16'h0000;
          3:       sensor_word = 16'hFFFF;
          default: sensor_word = 16'($urandom);
        endcase
      end
    end else begin
      st = ($urandom_range(99) < 5);
    end
    send_item(st, ln);
  endtask

  task automatic settle_idle();
    in_ch.valid <= 1'b0;
    while (trk.pending.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic run_phase(input int budget, input int absent_pct, input int start_pct);
    for (int i = 0; i < budget; i++) send_modeled(start_pct, absent_pct);
    while (trk.phase != PH_IDLE) send_modeled(0, absent_pct);
    settle_idle();
  endtask

  task automatic put_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
  endtask

  task automatic write_all_cfg(input owtr_cfg_t c);
    settle_idle();
    put_reg(REG_RESET_LOW, CfgDataW'(c.reset_low_us));
    put_reg(REG_PRES_TMO, CfgDataW'(c.presence_timeout_us));
    put_reg(REG_GAP, CfgDataW'(c.after_reset_gap_us));
    put_reg(REG_SLOT, CfgDataW'(c.slot_us));
    put_reg(REG_SAMPLE, CfgDataW'(c.sample_us));
    put_reg(REG_RECOVERY, CfgDataW'(c.recovery_us));
    put_reg(REG_CONV_WAIT, CfgDataW'(c.convert_wait_us));
    cfg_we <= 1'b0;
    trk.cfg = c;
    n_settings++;
  endtask

  function automatic owtr_cfg_t make_cfg(input int unsigned rst_low, input int unsigned tmo,
                                         input int unsigned gap, input int unsigned slot,
                                         input int unsigned samp, input int unsigned rec,
                                         input int unsigned conv);
    owtr_cfg_t c;
    c.reset_low_us = 10'(rst_low);
    c.presence_timeout_us = 13'(tmo);
    c.after_reset_gap_us = 11'(gap);
    c.slot_us = 7'(slot);
    c.sample_us = 5'(samp);
    c.recovery_us = 4'(rec);
    c.convert_wait_us = 20'(conv);
    return c;
  endfunction

  // Short timings keep a whole sequence to about two hundred ticks.
  function automatic owtr_cfg_t rand_cfg();
    int unsigned samp;
    samp = ($urandom_range(3) == 0) ? $urandom_range(9) : $urandom_range(3);
    return make_cfg($urandom_range(4), $urandom_range(12), $urandom_range(3),
                    $urandom_range(4), samp, $urandom_range(2), $urandom_range(8));
  endfunction

  initial begin
    trk = new();
    rst_n <= 1'b0;
    in_ch.valid <= 1'b0;
    in_ch.start_req <= 1'b0;
    in_ch.line_in <= 1'b0;
    cfg_we <= 1'b0;
    cfg_index <= REG_RESET_LOW;
    cfg_wdata <= '0;
    hold_rx <= 1'b0;
    rx_idle_pct <= 70;
    tx_idle_pct = 8;
    n_settings = 0;
    dev_absent = 1'b1;
    dev_delay = 0;
    sensor_word = 16'h8000;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset timings: idle ticks only, any sequence at these timings runs for ages.
    send_item(1'b0, 1'b0);
    send_item(1'b0, 1'b1);
    send_item(1'b0, 1'b0);
    send_item(1'b0, 1'b1);
    settle_idle();

    // All-zero timings: zero sample point, one-tick slots, zero recovery.
    // A start followed by starts while busy.
    write_all_cfg(make_cfg(0, 0, 0, 0, 0, 0, 0));
    send_item(1'b1, 1'b1);
    send_item(1'b1, 1'b1);
    send_item(1'b1, 1'b0);
    run_phase(30, 30, 50);
    write_all_cfg(rand_cfg());
    fork
      hold_receiver(400);
    join_none
    run_phase(60, 15, 20);

    tx_idle_pct = 70;
    rx_idle_pct <= 8;
    write_all_cfg(rand_cfg());
    run_phase(60, 15, 20);

    tx_idle_pct = 0;
    rx_idle_pct <= 0;
    // longest conversion wait, never reached since the sensor stays silent
    write_all_cfg(make_cfg(5, 10, 3, 4, 2, 2, 20'hFFFFF));
    run_phase(40, 100, 60);
    // sample point past the end of a one-tick slot, longest presence timeout
    write_all_cfg(make_cfg(2, 8191, 1, 1, 5, 0, 4));
    run_phase(1, 0, 100);
    write_all_cfg(rand_cfg());
    run_phase(60, 15, 20);

    settle_idle();
    repeat (8) @(posedge clk);
    $display("Ran %0d ticks over %0d timing settings;", trk.n_ticks, n_settings);
    $display("%0d sequences ended, %0d without presence.", trk.n_done, trk.n_absent);
    if (trk.fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("%0d mismatches", trk.fail_count);
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

/* files.f */
+incdir+src
src/owtr_pkg.sv
src/owtr_if.sv
src/owtr_cfg.sv
src/owtr_seq.sv
src/one_wire_temperature_reader.sv
tb/sv/tb_one_wire_temperature_reader.sv
